[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the gapped segment append unit.
// Needs clk and arst_n in the scope of each use; compiled away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("gapped segment append assertion failed");
`define GSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gapped segment append implication failed");
`else
`define GSA_ASSERT(lbl, prop)
`define GSA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hdl/gsa_pkg.sv]
// Shared types and constants of the gapped segment append unit.
// No dependencies; used by the channel interfaces and the top level.
package gsa_pkg;

	localparam int CMD_W      = 2;
	localparam int OWNER_W    = 8;
	localparam int VAL_W      = 32;
	localparam int POS_W      = 12;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int WIN_W      = 9;
	localparam int SLOT_W     = 5;
	localparam int LFSR_W     = 16;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	localparam logic [WIN_W-1:0]  FIRST_OWNER_RST = 9'd0;
	localparam logic [WIN_W-1:0]  OWNER_LIMIT_RST = 9'd256;
	localparam logic [SLOT_W-1:0] SLOT_SIZE_RST   = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_LAYOUT = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_APPEND = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_JAM   = 2'd1,
		STS_OVF   = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_OWNER = 2'd0,
		CFG_OWNER_LIMIT = 2'd1,
		CFG_SLOT_SIZE   = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

endpackage

[hdl/gsa_if.sv]
// Valid/ready channel interfaces of the gapped segment append unit.
// Depends on gsa_pkg for the field widths.
interface gsa_req_if import gsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [OWNER_W-1:0]      owner;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;

	modport source (output valid, command, owner, value, position, input ready);
	modport sink (input valid, command, owner, value, position, output ready);
endinterface

interface gsa_rsp_if import gsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_W-1:0]        owner_count;

	modport source (output valid, status, read_value, owner_count, input ready);
	modport sink (input valid, status, read_value, owner_count, output ready);
endinterface

interface gsa_cfg_if import gsa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/gapped_segment_append_unit.sv]
// Top level of the gapped segment append unit: bounds memory, entry memory and sequencer.
// Depends on gsa_pkg, the channel interfaces in gsa_if.sv and assert_macros.svh.
//
// Usage: commands arrive as words on req (layout, clear, append, read) and each one
// produces exactly one result word on rsp (status, read value, owner count). The
// configuration channel cfg is always ready and writes first_owner, owner_limit and
// slot_size by index; it should only be used while no command is in flight.
// One command is worked on at a time. An append into free space writes its entry at the
// end of the segment. An append that meets its neighbor first walks to the left and to
// the right over pairs of bounds (a walk stops at the window edge), makes a decision,
// then shifts each segment between the owner and the chosen gap by one place. The bounds
// memory has a single read port; layout and clear make one bounds access per cycle.
// After reset the bounds memory is laid out by a sweep during which req is not ready;
// the entry memory is not cleared.
// The result sits in an output register, so the sequencer finishes its work while
// an earlier result is still waiting; if the receiver stalls, the sequencer holds in
// its final state until the output register is free, then req becomes ready again.
`include "assert_macros.svh"

module gapped_segment_append_unit import gsa_pkg::*; #(
	parameter int OWNERS      = 256,
	parameter int STORE_DEPTH = 4096,
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	gsa_req_if.sink    req,
	gsa_rsp_if.source  rsp,
	gsa_cfg_if.sink    cfg
);

	// Owner index wide enough to hold OWNERS itself, bounds address, bound value.
	localparam int OW     = $clog2(OWNERS + 1);
	localparam int BAW    = $clog2(2 * OWNERS + 1);
	localparam int BDEPTH = 2 * OWNERS + 1;
	localparam int BW     = $clog2(STORE_DEPTH + 1);
	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int SW     = ((BW > POS_W) ? BW : POS_W) + 1;
	localparam int XW     = (OW > OWNER_W) ? OW : OWNER_W;
	localparam int WW     = (OW > WIN_W) ? OW : WIN_W;
	localparam int DW     = (VALUE_WIDTH > VAL_W) ? VALUE_WIDTH : VAL_W;
	localparam int SPMAX  = STORE_DEPTH / OWNERS;
	localparam int SP_RST = (SPMAX < 16) ? SPMAX : 16;

	typedef enum logic [21:0] {
		ST_IDLE   = 22'h000001,
		ST_SWEEP  = 22'h000002,
		ST_CLR_RD = 22'h000004,
		ST_CLR_WR = 22'h000008,
		ST_RD_S   = 22'h000010,
		ST_RD_E   = 22'h000020,
		ST_RD_N   = 22'h000040,
		ST_RD_D   = 22'h000080,
		ST_CHK    = 22'h000100,
		ST_LS0    = 22'h000200,
		ST_LS1    = 22'h000400,
		ST_LS2    = 22'h000800,
		ST_RS0    = 22'h001000,
		ST_RS1    = 22'h002000,
		ST_RS2    = 22'h004000,
		ST_DEC    = 22'h008000,
		ST_SH0    = 22'h010000,
		ST_SH1    = 22'h020000,
		ST_SH2    = 22'h040000,
		ST_SH3    = 22'h080000,
		ST_AP     = 22'h100000,
		ST_FIN    = 22'h200000
	} state_t;

	function automatic logic [BAW-1:0] ev(input logic [OW-1:0] x);
		return BAW'({x, 1'b0});
	endfunction

	// Memories: bounds (start 2i, end 2i+1, stopper at 2*OWNERS) and entries.
	logic [BW-1:0]          bounds_mem [BDEPTH];
	logic [VALUE_WIDTH-1:0] store_mem  [STORE_DEPTH];

	logic [BAW-1:0]         br_addr, bw_addr;
	logic                   bw_en;
	logic [BW-1:0]          bw_data, b_rd_q;
	logic [AW-1:0]          sr_addr, sw_addr;
	logic                   sw_en;
	logic [VALUE_WIDTH-1:0] sw_data, st_rd_q;

	// Control state.
	state_t              state_q;
	logic                init_q;
	logic [LFSR_W-1:0]   lfsr_q;
	logic                out_valid_q;
	logic [WIN_W-1:0]    first_owner_q, owner_limit_q;
	logic [SLOT_W-1:0]   slot_size_q;
	logic [BW-1:0]       sp_q, acc_q;
	logic [BAW-1:0]      idx_q;

	// Working registers of the current command.
	cmd_t                cmd_q;
	logic [OW-1:0]       o_q, j_q, k_q, a_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]    pos_q;
	logic [BW-1:0]       s_q, e_q, n_q, sj_q, ek_q, bs_q, be_q;
	logic [BW-1:0]       dst_q;
	logic                dst_ok_q, src_ok_q, rd_ok_q;
	logic                has_l_q, has_r_q, left_q;
	logic [CNT_W-1:0]    cnt_q;

	// Result waiting for the output register, and the output register itself.
	status_t             res_status_q, out_status_q;
	logic [VAL_W-1:0]    res_data_q, out_data_q;
	logic [CNT_W-1:0]    res_cnt_q, out_cnt_q;

	logic [OW-1:0]       lo_c, hi_c, o1_c;
	logic [SW-1:0]       rsum_c;
	logic [BW-1:0]       dl_c, dr_c, src_c, dst_c, sp_sel_c;
	logic                go_l_c, tie_c;
	logic [DW-1:0]       rd_ext_c;
	logic                out_free_c, fin_go_c;

	// Window registers beyond OWNERS act as OWNERS.
	assign lo_c = (WW'(first_owner_q) > WW'(OWNERS)) ? OW'(OWNERS) : OW'(first_owner_q);
	assign hi_c = (WW'(owner_limit_q) > WW'(OWNERS)) ? OW'(OWNERS) : OW'(owner_limit_q);
	assign o1_c = o_q + OW'(1);

	assign rsum_c   = SW'(s_q) + SW'(pos_q);
	assign dl_c     = e_q - sj_q;
	assign dr_c     = ek_q - n_q;
	assign tie_c    = has_l_q && has_r_q && (dl_c == dr_c);
	assign go_l_c   = has_l_q && (!has_r_q || (dl_c < dr_c) || (tie_c && lfsr_q[0]));
	assign src_c    = left_q ? (b_rd_q - BW'(1)) : bs_q;
	assign dst_c    = left_q ? (bs_q - BW'(1)) : b_rd_q;
	assign sp_sel_c = (int'(slot_size_q) > SPMAX) ? BW'(SPMAX) : BW'(slot_size_q);
	assign rd_ext_c = DW'(st_rd_q);

	assign out_free_c = !out_valid_q || rsp.ready;
	// The finished result moves into the output register in this cycle.
	assign fin_go_c   = (state_q == ST_FIN) && out_free_c;

	always_ff @(posedge clk) begin
		if (bw_en) begin
			bounds_mem[bw_addr] <= bw_data;
		end
		b_rd_q <= bounds_mem[br_addr];
	end

	always_ff @(posedge clk) begin
		if (sw_en) begin
			store_mem[sw_addr] <= sw_data;
		end
		st_rd_q <= store_mem[sr_addr];
	end

	// Memory port control follows the sequencer state.
	always_comb begin
		br_addr = '0;
		bw_en   = 1'b0;
		bw_addr = '0;
		bw_data = '0;
		sr_addr = '0;
		sw_en   = 1'b0;
		sw_addr = '0;
		sw_data = '0;
		unique case (state_q)
			ST_SWEEP: begin
				bw_en   = 1'b1;
				bw_addr = idx_q;
				bw_data = acc_q;
			end
			ST_CLR_RD: br_addr = ev(a_q);
			ST_CLR_WR: begin
				bw_en   = 1'b1;
				bw_addr = ev(a_q) + BAW'(1);
				bw_data = b_rd_q;
			end
			ST_RD_S: br_addr = ev(o_q);
			ST_RD_E: br_addr = ev(o_q) + BAW'(1);
			ST_RD_N: begin
				br_addr = ev(o_q) + BAW'(2);
				sr_addr = AW'(rsum_c);
			end
			ST_LS0: br_addr = ev(j_q);
			ST_LS1: br_addr = ev(j_q) - BAW'(1);
			ST_RS0: br_addr = ev(k_q) + BAW'(1);
			ST_RS1: br_addr = ev(k_q) + BAW'(2);
			ST_SH0: br_addr = ev(a_q);
			ST_SH1: br_addr = ev(a_q) + BAW'(1);
			ST_SH2: begin
				bw_en   = 1'b1;
				bw_addr = ev(a_q);
				bw_data = left_q ? (bs_q - BW'(1)) : (bs_q + BW'(1));
				sr_addr = AW'(src_c);
			end
			ST_SH3: begin
				bw_en   = 1'b1;
				bw_addr = ev(a_q) + BAW'(1);
				bw_data = left_q ? (be_q - BW'(1)) : (be_q + BW'(1));
				sw_en   = dst_ok_q && src_ok_q;
				sw_addr = AW'(dst_q);
				sw_data = st_rd_q;
			end
			ST_AP: begin
				bw_en   = 1'b1;
				bw_addr = ev(o_q) + BAW'(1);
				bw_data = e_q + BW'(1);
				sw_en   = e_q < BW'(STORE_DEPTH);
				sw_addr = AW'(e_q);
				sw_data = VALUE_WIDTH'($unsigned(val_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			init_q        <= 1'b1;
			lfsr_q        <= LFSR_SEED;
			out_valid_q   <= 1'b0;
			first_owner_q <= FIRST_OWNER_RST;
			owner_limit_q <= OWNER_LIMIT_RST;
			slot_size_q   <= SLOT_SIZE_RST;
			sp_q          <= BW'(SP_RST);
			acc_q         <= '0;
			idx_q         <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_FIRST_OWNER: first_owner_q <= cfg.data;
					CFG_OWNER_LIMIT: owner_limit_q <= cfg.data;
					CFG_SLOT_SIZE:   slot_size_q <= cfg.data[SLOT_W-1:0];
					default: ;
				endcase
			end
			if (fin_go_c) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q <= cmd_t'(req.command);
						o_q   <= OW'(req.owner);
						val_q <= req.value;
						pos_q <= req.position;
						res_data_q <= '0;
						res_cnt_q  <= '0;
						res_status_q <= STS_OK;
						priority if (cmd_t'(req.command) == CMD_LAYOUT) begin
							sp_q    <= sp_sel_c;
							acc_q   <= '0;
							idx_q   <= '0;
							state_q <= ST_SWEEP;
						end else if (cmd_t'(req.command) == CMD_CLEAR) begin
							a_q     <= '0;
							state_q <= ST_CLR_RD;
						end else if (XW'(req.owner) >= XW'(OWNERS)) begin
							res_status_q <= STS_RANGE;
							state_q      <= ST_FIN;
						end else begin
							state_q <= ST_RD_S;
						end
					end
				end
				ST_SWEEP: begin
					if (idx_q == BAW'(2 * OWNERS)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_FIN;
					end else begin
						idx_q <= idx_q + BAW'(1);
						if (idx_q[0]) begin
							acc_q <= acc_q + sp_q;
						end
					end
				end
				ST_CLR_RD: state_q <= ST_CLR_WR;
				ST_CLR_WR: begin
					if (a_q == OW'(OWNERS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						a_q     <= a_q + OW'(1);
						state_q <= ST_CLR_RD;
					end
				end
				ST_RD_S: state_q <= ST_RD_E;
				ST_RD_E: begin
					s_q     <= b_rd_q;
					state_q <= ST_RD_N;
				end
				ST_RD_N: begin
					e_q   <= b_rd_q;
					cnt_q <= CNT_W'(b_rd_q - s_q);
					res_cnt_q <= CNT_W'(b_rd_q - s_q);
					if (cmd_q == CMD_READ) begin
						if (CNT_W'(pos_q) < CNT_W'(b_rd_q - s_q)) begin
							rd_ok_q <= rsum_c < SW'(STORE_DEPTH);
							state_q <= ST_RD_D;
						end else begin
							res_status_q <= STS_RANGE;
							state_q      <= ST_FIN;
						end
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_RD_D: begin
					res_data_q <= rd_ok_q ? rd_ext_c[VAL_W-1:0] : '0;
					state_q    <= ST_FIN;
				end
				ST_CHK: begin
					n_q <= b_rd_q;
					j_q <= o_q;
					k_q <= o1_c;
					priority if (e_q > b_rd_q) begin
						res_status_q <= STS_OVF;
						state_q      <= ST_FIN;
					end else if (e_q < b_rd_q) begin
						state_q <= ST_AP;
					end else if ((o_q < lo_c) || (o_q >= hi_c)) begin
						res_status_q <= STS_JAM;
						state_q      <= ST_FIN;
					end else begin
						state_q <= ST_LS0;
					end
				end
				// Walk left while the start of owner j touches the end of owner j-1.
				ST_LS0: begin
					if (j_q > lo_c) begin
						state_q <= ST_LS1;
					end else begin
						has_l_q <= 1'b0;
						state_q <= ST_RS0;
					end
				end
				ST_LS1: begin
					sj_q    <= b_rd_q;
					state_q <= ST_LS2;
				end
				ST_LS2: begin
					if (b_rd_q == sj_q) begin
						j_q     <= j_q - OW'(1);
						state_q <= ST_LS0;
					end else begin
						has_l_q <= 1'b1;
						state_q <= ST_RS0;
					end
				end
				// Walk right while the end of owner k touches the start of owner k+1.
				ST_RS0: begin
					if (k_q < hi_c) begin
						state_q <= ST_RS1;
					end else begin
						has_r_q <= 1'b0;
						state_q <= ST_DEC;
					end
				end
				ST_RS1: begin
					ek_q    <= b_rd_q;
					state_q <= ST_RS2;
				end
				ST_RS2: begin
					if (b_rd_q == ek_q) begin
						k_q     <= k_q + OW'(1);
						state_q <= ST_RS0;
					end else begin
						has_r_q <= 1'b1;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (!has_l_q && !has_r_q) begin
						res_status_q <= STS_JAM;
						state_q      <= ST_FIN;
					end else begin
						if (tie_c) begin
							lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
						end
						left_q  <= go_l_c;
						a_q     <= go_l_c ? j_q : k_q;
						state_q <= ST_SH0;
					end
				end
				// Shift segment a by one place: both of its bounds move and one boundary entry is copied.
				ST_SH0: state_q <= ST_SH1;
				ST_SH1: begin
					bs_q    <= b_rd_q;
					state_q <= ST_SH2;
				end
				ST_SH2: begin
					be_q     <= b_rd_q;
					dst_q    <= dst_c;
					dst_ok_q <= dst_c < BW'(STORE_DEPTH);
					src_ok_q <= src_c < BW'(STORE_DEPTH);
					state_q  <= ST_SH3;
				end
				ST_SH3: begin
					if (left_q) begin
						if (a_q == o_q) begin
							e_q     <= e_q - BW'(1);
							state_q <= ST_AP;
						end else begin
							a_q     <= a_q + OW'(1);
							state_q <= ST_SH0;
						end
					end else begin
						if (a_q == o1_c) begin
							state_q <= ST_AP;
						end else begin
							a_q     <= a_q - OW'(1);
							state_q <= ST_SH0;
						end
					end
				end
				ST_AP: begin
					res_cnt_q <= cnt_q + CNT_W'(1);
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free_c) begin
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						out_cnt_q    <= res_cnt_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.read_value  = out_data_q;
	assign rsp.owner_count = out_cnt_q;

	// Nothing is accepted before the power-up layout sweep has finished.
	`GSA_ASSERT_IMP(a_no_accept_in_init, req.valid && req.ready, !init_q)
	// The tie-break generator never falls into its all-zero lockup state.
	`GSA_ASSERT(a_lfsr_live, lfsr_q != '0)
	// A new result only appears after the sequencer reached its final state.
	`GSA_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN))

endmodule
